/* rtl/core/pairwise_dot_product_matrix_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise dot product matrix block
// Short forms for clocked implications with a reset disable.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_DOT_PRODUCT_MATRIX_DEFINES_SVH
`define PAIRWISE_DOT_PRODUCT_MATRIX_DEFINES_SVH

// same-cycle implication
`define PDPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/pdpm_pkg.sv */
// ----------------------------------------------------------------------------
// pdpm_pkg
// Shared constants, codes and interface types of the dot product matrix block.
// ----------------------------------------------------------------------------
package pdpm_pkg;

   localparam int PDPM_MAX_VECTORS = 8;
   localparam int PDPM_MAX_LENGTH  = 256;

   // compare width for lengths and element positions (holds up to 8191)
   localparam int PDPM_LEN_CMP_W = 13;
   // vector counters, able to hold the count itself
   localparam int PDPM_CNT_W     = 4;
   localparam int PDPM_ADDR_W    = 4;
   localparam int PDPM_DATA_W    = 32;

   // register indexes, paddr[3:2]
   localparam logic [1:0] CSR_IDX_LENGTH = 2'd0;
   localparam logic [1:0] CSR_IDX_FIRST  = 2'd1;
   localparam logic [1:0] CSR_IDX_SECOND = 2'd2;
   localparam logic [1:0] CSR_IDX_MODE   = 2'd3;

   // pairing modes; the fourth code behaves as self
   localparam logic [1:0] MODE_SELF  = 2'd0;
   localparam logic [1:0] MODE_CROSS = 2'd1;
   localparam logic [1:0] MODE_INDEP = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENTRY,
      ST_RUN,
      ST_EMIT
   } pdpm_state_type;

   typedef struct packed {
      logic [8:0] vector_length;
      logic [3:0] count_first;
      logic [3:0] count_second;
      logic [1:0] pairing_mode;
   } pdpm_cfg_type;

   typedef struct packed {
      logic load;        // element transaction accepted
      logic start;       // final element accepted, latch run setup
      logic entry_init;  // clear accumulator for the current entry
      logic issue;       // issue element reads for the current entry
      logic emit;        // load the result register and advance
   } pdpm_cmd_type;

   typedef struct packed {
      logic setup_error;
      logic setup_empty;
      logic entry_compute;
      logic mac_done;
      logic run_last;
      logic out_free;
   } pdpm_status_type;

endpackage

/* rtl/core/pdpm_csr.sv */
// ----------------------------------------------------------------------------
// pdpm_csr
// APB-style register bank: length, set counts and pairing mode.
// ----------------------------------------------------------------------------
module pdpm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pdpm_pkg::PDPM_ADDR_W-1:0]     csr_paddr,
   input  logic [pdpm_pkg::PDPM_DATA_W-1:0]     csr_pwdata,
   output logic [pdpm_pkg::PDPM_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready,
   output pdpm_pkg::pdpm_cfg_type               cfg
);
   import pdpm_pkg::*;

   logic [8:0] length_ff, length_in;
   logic [3:0] first_ff, first_in;
   logic [3:0] second_ff, second_in;
   logic [1:0] mode_ff, mode_in;
   logic       wr_en;
   logic [1:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[3:2];

   always_comb begin
      length_in = length_ff;
      first_in  = first_ff;
      second_in = second_ff;
      mode_in   = mode_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_IDX_LENGTH: length_in = csr_pwdata[8:0];
            CSR_IDX_FIRST:  first_in  = csr_pwdata[3:0];
            CSR_IDX_SECOND: second_in = csr_pwdata[3:0];
            CSR_IDX_MODE:   mode_in   = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= 9'd1;
         first_ff  <= 4'd1;
         second_ff <= 4'd1;
         mode_ff   <= MODE_SELF;
      end else begin
         length_ff <= length_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      unique case (idx)
         CSR_IDX_LENGTH: csr_prdata = PDPM_DATA_W'(length_ff);
         CSR_IDX_FIRST:  csr_prdata = PDPM_DATA_W'(first_ff);
         CSR_IDX_SECOND: csr_prdata = PDPM_DATA_W'(second_ff);
         CSR_IDX_MODE:   csr_prdata = PDPM_DATA_W'(mode_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.vector_length = length_ff;
   assign cfg.count_first   = first_ff;
   assign cfg.count_second  = second_ff;
   assign cfg.pairing_mode  = mode_ff;

endmodule

/* rtl/core/pdpm_dp.sv */
// ----------------------------------------------------------------------------
// pdpm_dp
// Datapath: vector stores, entry counters, multiply-accumulate pipeline and
// the result register.
// ----------------------------------------------------------------------------
module pdpm_dp #(
   parameter int MAX_VECTORS = pdpm_pkg::PDPM_MAX_VECTORS,
   parameter int MAX_LENGTH  = pdpm_pkg::PDPM_MAX_LENGTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pdpm_pkg::pdpm_cfg_type      cfg,
   input  pdpm_pkg::pdpm_cmd_type      cmd,
   output pdpm_pkg::pdpm_status_type   status,
   input  logic                        req_set_select,
   input  logic [2:0]                  req_vector_index,
   input  logic [7:0]                  req_element_index,
   input  logic signed [15:0]          req_value,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_row,
   output logic [2:0]                  rsp_column,
   output logic signed [39:0]          rsp_product,
   output logic                        rsp_last,
   output logic                        rsp_error
);
   import pdpm_pkg::*;

   localparam int VW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int LW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int KW    = $clog2(MAX_LENGTH + 1);
   localparam int AW    = VW + LW;
   localparam int DEPTH = MAX_VECTORS * (1 << LW);

   localparam logic [PDPM_CNT_W-1:0]     CNT_MAX = PDPM_CNT_W'(MAX_VECTORS);
   localparam logic [PDPM_LEN_CMP_W-1:0] LEN_MAX = PDPM_LEN_CMP_W'(MAX_LENGTH);

   logic [15:0] first_mem  [DEPTH];
   logic [15:0] second_mem [DEPTH];

   // ---------------- element loading
   logic [PDPM_LEN_CMP_W-1:0] wr_elem;
   logic                      wr_ok;
   logic [AW-1:0]             wr_addr;

   assign wr_elem = PDPM_LEN_CMP_W'(req_element_index);
   assign wr_ok   = (PDPM_CNT_W'(req_vector_index) < CNT_MAX) && (wr_elem < LEN_MAX);
   assign wr_addr = {req_vector_index[VW-1:0], wr_elem[LW-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok && !req_set_select) begin
         first_mem[wr_addr] <= req_value;
      end
      if (cmd.load && wr_ok && req_set_select) begin
         second_mem[wr_addr] <= req_value;
      end
   end

   // ---------------- run setup from the registers
   logic [1:0]                mode_set;
   logic [PDPM_CNT_W-1:0]     n1_set, n2_set, n2_cross;
   logic [PDPM_LEN_CMP_W-1:0] len_cmp;
   logic [KW-1:0]             len_set;

   always_comb begin
      unique case (cfg.pairing_mode)
         MODE_CROSS: mode_set = MODE_CROSS;
         MODE_INDEP: mode_set = MODE_INDEP;
         default:    mode_set = MODE_SELF;
      endcase
   end

   assign n1_set   = (cfg.count_first > CNT_MAX) ? CNT_MAX : cfg.count_first;
   assign n2_cross = (cfg.count_second > CNT_MAX) ? CNT_MAX : cfg.count_second;
   assign n2_set   = (mode_set == MODE_CROSS) ? n2_cross : n1_set;
   assign len_cmp  = PDPM_LEN_CMP_W'(cfg.vector_length);
   assign len_set  = (len_cmp > LEN_MAX) ? KW'(MAX_LENGTH) : KW'(len_cmp);

   assign status.setup_error = (mode_set == MODE_INDEP) &&
                               (cfg.count_first != cfg.count_second);
   assign status.setup_empty = (n1_set == '0) || (n2_set == '0);

   // ---------------- run and entry state
   logic [1:0]            mode_ff, mode_in;
   logic [PDPM_CNT_W-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic [PDPM_CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [KW-1:0]         len_ff, len_in;
   logic                  err_ff, err_in;
   logic                  last_pair;

   assign last_pair = (i_ff == n1_ff - 1'b1) && (j_ff == n2_ff - 1'b1);

   always_comb begin
      mode_in = mode_ff;
      n1_in   = n1_ff;
      n2_in   = n2_ff;
      len_in  = len_ff;
      err_in  = err_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      if (cmd.start) begin
         mode_in = mode_set;
         n1_in   = n1_set;
         n2_in   = n2_set;
         len_in  = len_set;
         err_in  = status.setup_error;
         i_in    = '0;
         j_in    = '0;
      end else if (cmd.emit) begin
         if (j_ff + 1'b1 == n2_ff) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SELF;
         n1_ff   <= '0;
         n2_ff   <= '0;
         len_ff  <= '0;
         err_ff  <= 1'b0;
         i_ff    <= '0;
         j_ff    <= '0;
      end else begin
         mode_ff <= mode_in;
         n1_ff   <= n1_in;
         n2_ff   <= n2_in;
         len_ff  <= len_in;
         err_ff  <= err_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
      end
   end

   assign status.entry_compute = ((mode_ff != MODE_INDEP) || (i_ff == j_ff)) &&
                                 (len_ff != '0);
   assign status.run_last      = err_ff || last_pair;

   // ---------------- multiply-accumulate pipeline: read, multiply, add
   logic [KW-1:0]      k_ff, k_in;
   logic               rd_v_ff, rd_v_in, mul_v_ff, mul_v_in;
   logic               issue_fire;
   logic [AW-1:0]      row_addr, col_addr;
   logic [15:0]        row_q, self_q, cross_q;
   logic signed [15:0] col_sel;
   logic signed [31:0] mul_ff;
   logic signed [39:0] acc_ff, acc_in;

   assign issue_fire = cmd.issue && (k_ff < len_ff);
   assign row_addr   = {i_ff[VW-1:0], k_ff[LW-1:0]};
   assign col_addr   = {j_ff[VW-1:0], k_ff[LW-1:0]};

   always_ff @(posedge clock) begin
      row_q   <= first_mem[row_addr];
      self_q  <= first_mem[col_addr];
      cross_q <= second_mem[col_addr];
   end

   // self mode pairs set one with itself, both other modes use set two
   assign col_sel = (mode_ff == MODE_SELF) ? $signed(self_q) : $signed(cross_q);

   always_ff @(posedge clock) begin
      mul_ff <= $signed(row_q) * col_sel;
   end

   always_comb begin
      k_in     = k_ff;
      rd_v_in  = issue_fire;
      mul_v_in = rd_v_ff;
      acc_in   = acc_ff;
      if (cmd.entry_init) begin
         k_in     = '0;
         rd_v_in  = 1'b0;
         mul_v_in = 1'b0;
         acc_in   = '0;
      end else begin
         if (issue_fire) begin
            k_in = k_ff + 1'b1;
         end
         if (mul_v_ff) begin
            acc_in = acc_ff + {{8{mul_ff[31]}}, mul_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         rd_v_ff  <= rd_v_in;
         mul_v_ff <= mul_v_in;
      end
      acc_ff <= acc_in;
   end

   assign status.mac_done = (k_ff == len_ff) && !rd_v_ff && !mul_v_ff;

   // ---------------- result register
   logic               out_v_ff, out_v_in;
   logic [2:0]         row_ff, col_ff;
   logic signed [39:0] prod_ff;
   logic               last_ff, oerr_ff;

   assign status.out_free = !out_v_ff || !rsp_stall;

   always_comb begin
      out_v_in = out_v_ff;
      if (cmd.emit) begin
         out_v_in = 1'b1;
      end else if (!rsp_stall) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      if (cmd.emit) begin
         if (err_ff) begin
            row_ff  <= '0;
            col_ff  <= '0;
            prod_ff <= '0;
            last_ff <= 1'b1;
            oerr_ff <= 1'b1;
         end else begin
            row_ff  <= i_ff[2:0];
            col_ff  <= j_ff[2:0];
            prod_ff <= acc_ff;
            last_ff <= last_pair;
            oerr_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_row     = row_ff;
   assign rsp_column  = col_ff;
   assign rsp_product = prod_ff;
   assign rsp_last    = last_ff;
   assign rsp_error   = oerr_ff;

endmodule

/* rtl/core/pdpm_ctrl.sv */
// ----------------------------------------------------------------------------
// pdpm_ctrl
// Controller: element loading, then one pass per matrix entry.
// ----------------------------------------------------------------------------
module pdpm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_load_done,
   output logic                        req_stall,
   input  pdpm_pkg::pdpm_status_type   status,
   output pdpm_pkg::pdpm_cmd_type      cmd
);
   import pdpm_pkg::*;

   pdpm_state_type state_ff, state_in;
   logic           accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_load_done) begin
               if (status.setup_error) begin
                  state_in = ST_EMIT;
               end else if (!status.setup_empty) begin
                  state_in = ST_ENTRY;
               end
            end
         end
         ST_ENTRY: begin
            state_in = status.entry_compute ? ST_RUN : ST_EMIT;
         end
         ST_RUN: begin
            if (status.mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.run_last ? ST_IDLE : ST_ENTRY;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      cmd.load       = accept;
      cmd.start      = accept && req_load_done;
      cmd.entry_init = (state_ff == ST_ENTRY);
      cmd.issue      = (state_ff == ST_RUN);
      cmd.emit       = (state_ff == ST_EMIT) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/pairwise_dot_product_matrix.sv */
// ----------------------------------------------------------------------------
// pairwise_dot_product_matrix
// Gram matrix of up to MAX_VECTORS signed Q8.8 vectors, exact 40-bit sums.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one vector element per transaction (set, vector, position,
//   value). While loading, one element is taken every cycle. An element with
//   req_load_done set is stored and then starts the matrix run; req_stall is
//   high for the whole run.
//   rsp_* returns the entries in row-major order, rsp_last on the final one.
//   Independent mode with unequal counts returns a single error transaction.
//   csr_* is an APB-style port, zero wait states; write only while idle.
// Sequence (L = clamped vector_length):
//   a computed entry has a setup step, L reads on the store ports, then the
//   read, multiply and accumulate registers, then a step into the result
//   register. An entry not computed goes from setup to the result register.
// Stall: the result register holds its transaction; the run computes the
//   next entry and holds it until the register is free.
// Reset: registers return to length 1, counts 1, self mode. The stores are
//   not cleared and hold nothing usable until loaded.
// ----------------------------------------------------------------------------
module pairwise_dot_product_matrix #(
   parameter int MAX_VECTORS = pdpm_pkg::PDPM_MAX_VECTORS,
   parameter int MAX_LENGTH  = pdpm_pkg::PDPM_MAX_LENGTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_set_select,
   input  logic [2:0]                           req_vector_index,
   input  logic [7:0]                           req_element_index,
   input  logic signed [15:0]                   req_value,
   input  logic                                 req_load_done,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_row,
   output logic [2:0]                           rsp_column,
   output logic signed [39:0]                   rsp_product,
   output logic                                 rsp_last,
   output logic                                 rsp_error,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pdpm_pkg::PDPM_ADDR_W-1:0]     csr_paddr,
   input  logic [pdpm_pkg::PDPM_DATA_W-1:0]     csr_pwdata,
   output logic [pdpm_pkg::PDPM_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import pdpm_pkg::*;

   pdpm_cfg_type    cfg;
   pdpm_cmd_type    cmd;
   pdpm_status_type status;

   pdpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdpm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_load_done (req_load_done),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   pdpm_dp #(
      .MAX_VECTORS (MAX_VECTORS),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_set_select    (req_set_select),
      .req_vector_index  (req_vector_index),
      .req_element_index (req_element_index),
      .req_value         (req_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_row           (rsp_row),
      .rsp_column        (rsp_column),
      .rsp_product       (rsp_product),
      .rsp_last          (rsp_last),
      .rsp_error         (rsp_error)
   );

endmodule

/* rtl/core/pdpm_checker.sv */
// ----------------------------------------------------------------------------
// pdpm_checker
// Port-level checks of the dot product matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pairwise_dot_product_matrix_defines.svh"

module pdpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_load_done,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_row,
   input logic [2:0]  rsp_column,
   input logic [39:0] rsp_product,
   input logic        rsp_last,
   input logic        rsp_error
);

   // a held result keeps its whole transaction
   `PDPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_row) && $stable(rsp_column) && $stable(rsp_product) && $stable(rsp_last) && $stable(rsp_error), "result changed while stalled")

   // the error transaction is a lone, empty, final entry
   `PDPM_ASSERT_SAME(a_err_shape, clock, reset, rsp_valid && rsp_error, rsp_last && (rsp_row == 3'd0) && (rsp_column == 3'd0) && (rsp_product == 40'd0), "malformed error result")

   // input stays closed until the run's final entry is out
   `PDPM_ASSERT_SAME(a_run_blocks_input, clock, reset, rsp_valid && !rsp_last, req_stall, "input open during a run")

   // plain element loads keep the input open
   `PDPM_ASSERT_NEXT(a_load_streams, clock, reset, req_valid && !req_stall && !req_load_done, !req_stall, "stall after a plain load")

endmodule

bind pairwise_dot_product_matrix pdpm_checker u_pdpm_checker (.*);

/* verif/pairwise_dot_product_matrix_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_dot_product_matrix_tb
// Streams vector elements into the dot product matrix block under every
// pairing mode and a range of register settings. A scoreboard keeps its own
// copy of both vector stores and predicts each matrix entry. Random gaps on
// the element side and random stalls on the result side, plus one long hold.
// ----------------------------------------------------------------------------
module pairwise_dot_product_matrix_tb;
   import pdpm_pkg::*;

   localparam int          VEC_MAX         = PDPM_MAX_VECTORS;
   localparam int          LEN_MAX         = PDPM_MAX_LENGTH;
   localparam logic [1:0]  MODE_ALIAS_SELF = 2'd3;
   localparam int          LIMIT_CYCLES    = 40000000;
   localparam int          RANDOM_ITEMS    = 60;
   localparam int          SETTLE_CYCLES   = 40;
   localparam int          HOLD_CYCLES     = 500;

   typedef struct packed {
      logic [2:0]         row;
      logic [2:0]         column;
      logic signed [39:0] product;
      logic               last;
      logic               error;
   } matrix_entry_type;

   typedef struct packed {
      logic        set;
      logic [2:0]  vec;
      logic [7:0]  pos;
      logic [15:0] value;
   } element_type;

   // ------------------------------------------------------------------------
   class gram_scoreboard;
      logic signed [15:0] set_one [VEC_MAX][LEN_MAX];
      logic signed [15:0] set_two [VEC_MAX][LEN_MAX];
      logic [8:0]         length_reg;
      logic [3:0]         first_reg;
      logic [3:0]         second_reg;
      logic [1:0]         mode_reg;
      matrix_entry_type   entries[$];
      int                 errors;

      function new();
         length_reg = 9'd1;
         first_reg  = 4'd1;
         second_reg = 4'd1;
         mode_reg   = MODE_SELF;
         errors     = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_IDX_LENGTH: length_reg = data[8:0];
            CSR_IDX_FIRST:  first_reg  = data[3:0];
            CSR_IDX_SECOND: second_reg = data[3:0];
            default:        mode_reg   = data[1:0];
         endcase
      endfunction

      function int pending();
         return entries.size();
      endfunction

      function longint dot_product(int a, int b, bit from_two, int len);
         longint acc;
         acc = 0;
         for (int k = 0; k < len; k++) begin
            if (from_two)
               acc += longint'(set_one[a][k]) * longint'(set_two[b][k]);
            else
               acc += longint'(set_one[a][k]) * longint'(set_one[b][k]);
         end
         return acc;
      endfunction

      // one accepted element transaction; a final element queues the matrix
      function void note_element(logic set, logic [2:0] vec, logic [7:0] pos,
                                 logic [15:0] value, logic done);
         logic [1:0]       mode;
         int               len, n1, n2, total, k;
         longint           acc;
         matrix_entry_type e;
         if (set)
            set_two[vec][pos] = value;
         else
            set_one[vec][pos] = value;
         if (!done)
            return;
         mode = (mode_reg == MODE_ALIAS_SELF) ? MODE_SELF : mode_reg;
         if (mode == MODE_INDEP && first_reg != second_reg) begin
            e = '0;
            e.last  = 1'b1;
            e.error = 1'b1;
            entries.insert(entries.size(), e);
            return;
         end
         len   = (length_reg > LEN_MAX) ? LEN_MAX : int'(length_reg);
         n1    = (first_reg > VEC_MAX) ? VEC_MAX : int'(first_reg);
         n2    = n1;
         if (mode == MODE_CROSS)
            n2 = (second_reg > VEC_MAX) ? VEC_MAX : int'(second_reg);
         total = n1 * n2;
         k     = 0;
         for (int i = 0; i < n1; i++) begin
            for (int j = 0; j < n2; j++) begin
               acc = 0;
               if (mode != MODE_INDEP || i == j)
                  acc = dot_product(i, j, mode != MODE_SELF, len);
               e.row     = 3'(i);
               e.column  = 3'(j);
               e.product = acc[39:0];
               e.last    = (k + 1 == total);
               e.error   = 1'b0;
               entries.insert(entries.size(), e);
               k++;
            end
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_result(logic [2:0] row, logic [2:0] column, logic [39:0] product,
                        logic last, logic error);
         matrix_entry_type want;
         if (entries.size() == 0) begin
            report($sformatf("unexpected result row %0d column %0d", row, column));
            return;
         end
         want = entries.pop_front();
         if (row !== want.row)
            report($sformatf("row got %0d want %0d", row, want.row));
         if (column !== want.column)
            report($sformatf("column got %0d want %0d (row %0d)", column, want.column,
                             want.row));
         if (product !== want.product)
            report($sformatf("product (%0d,%0d) got %0d want %0d", want.row, want.column,
                             $signed(product), want.product));
         if (last !== want.last)
            report($sformatf("last (%0d,%0d) got %b want %b", want.row, want.column,
                             last, want.last));
         if (error !== want.error)
            report($sformatf("error (%0d,%0d) got %b want %b", want.row, want.column,
                             error, want.error));
      endtask
   endclass
   // ------------------------------------------------------------------------

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_set_select = 1'b0;
   logic [2:0]         req_vector_index = '0;
   logic [7:0]         req_element_index = '0;
   logic signed [15:0] req_value = '0;
   logic               req_load_done = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_row;
   logic [2:0]         rsp_column;
   logic signed [39:0] rsp_product;
   logic               rsp_last;
   logic               rsp_error;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [PDPM_ADDR_W-1:0] csr_paddr = '0;
   logic [PDPM_DATA_W-1:0] csr_pwdata = '0;
   logic [PDPM_DATA_W-1:0] csr_prdata;
   logic               csr_pready;

   gram_scoreboard sb = new();

   // stimulus-side mirror of the registers and of which store words hold data
   logic [8:0]  cfg_length = 9'd1;
   logic [3:0]  cfg_first  = 4'd1;
   logic [3:0]  cfg_second = 4'd1;
   logic [1:0]  cfg_mode   = MODE_SELF;
   bit          loaded [2][VEC_MAX][LEN_MAX];
   bit          dense_run = 1'b0;
   int          items_sent = 0;
   logic        hold_arm = 1'b0;
   logic        hold_used = 1'b0;
   int          hold_left = 0;
   int          stall_left = 0;
   int unsigned cycle_count = 0;

   pairwise_dot_product_matrix dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_set_select    (req_set_select),
      .req_vector_index  (req_vector_index),
      .req_element_index (req_element_index),
      .req_value         (req_value),
      .req_load_done     (req_load_done),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_row           (rsp_row),
      .rsp_column        (rsp_column),
      .rsp_product       (rsp_product),
      .rsp_last          (rsp_last),
      .rsp_error         (rsp_error),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random stalls, and one long hold when armed
   always @(posedge clock) begin : stall_gen
      int r;
      if (hold_arm && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
         end else if (r < 62) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(20, 80);
         end else if (r < 94) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 60);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_result(rsp_row, rsp_column, rsp_product, rsp_last, rsp_error);
   end

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (dense_run || r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] reg_mask(logic [1:0] idx);
      case (idx) inside
         CSR_IDX_LENGTH:                return 32'h1FF;
         CSR_IDX_FIRST, CSR_IDX_SECOND: return 32'hF;
         default:                       return 32'h3;
      endcase
   endfunction

   function automatic element_type make_element(logic set, int vec, int pos, bit extreme);
      element_type el;
      el.set   = set;
      el.vec   = 3'(vec);
      el.pos   = 8'(pos);
      el.value = extreme ? 16'h8000 : pick_value();
      return el;
   endfunction

   // write, then read back; caller is just past a rising edge
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      logic [31:0] expected_read;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_register(idx, data);
      case (idx)
         CSR_IDX_LENGTH: cfg_length = data[8:0];
         CSR_IDX_FIRST:  cfg_first  = data[3:0];
         CSR_IDX_SECOND: cfg_second = data[3:0];
         default:        cfg_mode   = data[1:0];
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      expected_read = data & reg_mask(idx);
      if (csr_prdata !== expected_read)
         sb.report($sformatf("register %0d read %h want %h", idx, csr_prdata,
                             expected_read));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_element(input element_type el, input logic done);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_set_select    <= el.set;
      req_vector_index  <= el.vec;
      req_element_index <= el.pos;
      req_value         <= el.value;
      req_load_done     <= done;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      loaded[el.set][el.vec][el.pos] = 1'b1;
      items_sent++;
      sb.note_element(el.set, el.vec, el.pos, el.value, done);
   endtask

   // loads what the current setting reads (missing words plus some rewrites),
   // some stray elements, then the final element that starts the matrix
   task automatic matrix_run(input bit extreme);
      element_type plan[$];
      element_type tmp;
      logic [1:0]  mode;
      int          len, n1, n2, j;
      bit          flawed;
      mode   = (cfg_mode == MODE_ALIAS_SELF) ? MODE_SELF : cfg_mode;
      flawed = (mode == MODE_INDEP) && (cfg_first != cfg_second);
      len    = (cfg_length > LEN_MAX) ? LEN_MAX : int'(cfg_length);
      n1     = (cfg_first > VEC_MAX) ? VEC_MAX : int'(cfg_first);
      n2     = n1;
      if (mode == MODE_CROSS)
         n2 = (cfg_second > VEC_MAX) ? VEC_MAX : int'(cfg_second);
      dense_run = ($urandom_range(0, 3) == 0);
      if (!flawed && len > 0 && n1 > 0 && n2 > 0) begin
         for (int v = 0; v < n1; v++)
            for (int e = 0; e < len; e++)
               if (extreme || !loaded[0][v][e] || $urandom_range(0, 4) == 0)
                  plan.insert(plan.size(), make_element(1'b0, v, e, extreme));
         if (mode != MODE_SELF)
            for (int v = 0; v < n2; v++)
               for (int e = 0; e < len; e++)
                  if (extreme || !loaded[1][v][e] || $urandom_range(0, 4) == 0)
                     plan.insert(plan.size(), make_element(1'b1, v, e, extreme));
      end
      repeat ($urandom_range(0, 3))
         plan.insert(plan.size(), make_element(1'($urandom), $urandom_range(0, 7),
                                               $urandom_range(0, 255), 1'b0));
      for (int i = plan.size() - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         tmp     = plan[i];
         plan[i] = plan[j];
         plan[j] = tmp;
      end
      if (plan.size() == 0)
         plan.insert(plan.size(), make_element(1'($urandom), $urandom_range(0, 7),
                                               $urandom_range(0, 255), 1'b0));
      for (int i = 0; i < plan.size(); i++)
         send_element(plan[i], i == plan.size() - 1);
   endtask

   // registers change only once every queued entry is back and the block is quiet
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int len, input int first, input int second,
                            input logic [1:0] mode, input int runs, input bit extreme,
                            input bit hold);
      settle_idle();
      csr_write(CSR_IDX_LENGTH, 32'(len));
      csr_write(CSR_IDX_FIRST, 32'(first));
      csr_write(CSR_IDX_SECOND, 32'(second));
      csr_write(CSR_IDX_MODE, 32'(mode));
      if (hold)
         hold_arm <= 1'b1;
      repeat (runs) matrix_run(extreme);
   endtask

   initial begin
      int         len, first, second, runs, base, r;
      logic [1:0] mode;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one vector of one element
      matrix_run(1'b0);
      run_phase(4, 3, 1, MODE_SELF, 1, 1'b0, 1'b0);
      run_phase(4, 3, 5, MODE_CROSS, 1, 1'b0, 1'b0);
      run_phase(3, 4, 4, MODE_INDEP, 1, 1'b0, 1'b0);
      run_phase(3, 3, 5, MODE_INDEP, 1, 1'b0, 1'b0);        // unequal counts
      run_phase(2, 2, 6, MODE_ALIAS_SELF, 1, 1'b0, 1'b0);
      run_phase(0, 2, 3, MODE_CROSS, 1, 1'b0, 1'b0);        // zero length
      run_phase(2, 0, 4, MODE_SELF, 1, 1'b0, 1'b0);         // empty matrix
      run_phase(1, 4, 0, MODE_CROSS, 1, 1'b0, 1'b0);        // empty matrix
      run_phase(2, 15, 12, MODE_CROSS, 2, 1'b0, 1'b1);      // saturated counts, long hold
      run_phase(2, 9, 8, MODE_INDEP, 1, 1'b0, 1'b0);        // raw counts differ
      run_phase(2, 8, 8, MODE_INDEP, 1, 1'b0, 1'b0);
      run_phase(511, 1, 1, MODE_SELF, 1, 1'b1, 1'b0);       // saturated length, max sum

      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            len = $urandom_range(1, 8);
         else if (r < 88)
            len = $urandom_range(9, 24);
         else if (r < 93)
            len = 0;
         else
            len = $urandom_range(25, 40);
         r      = $urandom_range(0, 99);
         first  = (r < 5) ? 0 : (r < 13) ? $urandom_range(9, 15) : $urandom_range(1, 8);
         r      = $urandom_range(0, 99);
         second = (r < 5) ? 0 : (r < 13) ? $urandom_range(9, 15) : $urandom_range(1, 8);
         mode   = 2'($urandom_range(0, 3));
         if (mode == MODE_INDEP && $urandom_range(0, 4) != 0)
            second = first;
         if (len > 24) begin
            first  = $urandom_range(1, 2);
            second = (mode == MODE_INDEP) ? first : $urandom_range(1, 2);
         end
         runs = $urandom_range(1, 3);
         run_phase(len, first, second, mode, runs, 1'b0, 1'b0);
      end

      settle_idle();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
